### design/escaped_api_frame_parser_macros.svh
// Assertion macros shared by the frame parser checks.
`ifndef ESCAPED_API_FRAME_PARSER_MACROS_SVH
`define ESCAPED_API_FRAME_PARSER_MACROS_SVH

// Checked while out of reset.
`define EAFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define EAFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/eafp_pkg.sv
`default_nettype none

package eafp_pkg;

  // Parser phases, one-hot.
  typedef enum logic [11:0] {
    PH_WAIT     = 12'b0000_0000_0001,
    PH_LEN1     = 12'b0000_0000_0010,
    PH_LEN1_ESC = 12'b0000_0000_0100,
    PH_LEN2     = 12'b0000_0000_1000,
    PH_LEN2_ESC = 12'b0000_0001_0000,
    PH_DATA     = 12'b0000_0010_0000,
    PH_DATA_ESC = 12'b0000_0100_0000,
    PH_CK       = 12'b0000_1000_0000,
    PH_CK_ESC   = 12'b0001_0000_0000,
    PH_GOOD     = 12'b0010_0000_0000,
    PH_BAD      = 12'b0100_0000_0000,
    PH_UNEXP    = 12'b1000_0000_0000
  } phase_t;

  typedef logic [2:0] status_t;

  localparam status_t STATUS_WAIT     = 3'd0;
  localparam status_t STATUS_IN_FRAME = 3'd1;
  localparam status_t STATUS_GOOD     = 3'd2;
  localparam status_t STATUS_BAD      = 3'd3;
  localparam status_t STATUS_UNEXP    = 3'd4;

  localparam int unsigned CFG_IDX_BITS = 2;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_START_BYTE  = 2'd0;
  localparam cfg_idx_t CFG_ESCAPE_BYTE = 2'd1;
  localparam cfg_idx_t CFG_ESCAPE_MASK = 2'd2;

  localparam logic [7:0] START_BYTE_RST  = 8'h7E;
  localparam logic [7:0] ESCAPE_BYTE_RST = 8'h7D;
  localparam logic [7:0] ESCAPE_MASK_RST = 8'h20;
  localparam logic [7:0] CHECKSUM_OK     = 8'hFF;

  function automatic status_t status_of(input phase_t ph);
    status_t s;
    case (ph)
      PH_WAIT:  s = STATUS_WAIT;
      PH_GOOD:  s = STATUS_GOOD;
      PH_BAD:   s = STATUS_BAD;
      PH_UNEXP: s = STATUS_UNEXP;
      default:  s = STATUS_IN_FRAME;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### design/eafp_rx_if.sv
`default_nettype none

// Received byte channel.
interface eafp_rx_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

`default_nettype wire

### design/eafp_res_if.sv
`default_nettype none

// Per-byte result channel.
interface eafp_res_if;
  logic                 valid;
  logic                 ready;
  logic                 consumed;
  logic                 data_valid;
  logic [7:0]           data_byte;
  logic [15:0]          data_index;
  logic [15:0]          frame_length;
  eafp_pkg::status_t    status;

  modport source (output valid, output consumed, output data_valid, output data_byte,
                  output data_index, output frame_length, output status, input ready);
  modport sink   (input valid, input consumed, input data_valid, input data_byte,
                  input data_index, input frame_length, input status, output ready);
endinterface

`default_nettype wire

### design/escaped_api_frame_parser.sv
// Escaped API frame parser. Bytes arrive one per transfer on rx (kind 0 = byte,
// kind 1 = restart) and every transfer gives exactly one result transfer on res,
// in order. The parser skips bytes until the start byte, reads a big-endian length
// (kept in its low LEN_BITS bits), then the payload and an 8-bit checksum; any byte
// after the start byte may be escaped. Payload bytes come out with their index; a
// frame is good when checksum plus payload sum is 0xFF. A raw start byte inside a
// frame ends it as unexpected and is reported unconsumed, so the caller re-offers it
// after a restart. Good, bad and unexpected states hold until a restart. Throughput
// is one byte per clock: the parser state and the result register update in the
// same cycle a byte is taken, and rx stays ready while a result waits as long as
// res takes it in that cycle. res.valid rises in the cycle after the rx transfer.
// Configuration (start byte, escape byte, escape mask) is written via cfg_wr_en,
// cfg_index, cfg_data; the user must write it only while no byte is in flight (the block does not enforce this).

`default_nettype none

module escaped_api_frame_parser #(
  parameter int unsigned LEN_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire eafp_pkg::cfg_idx_t         cfg_index,
  input  wire logic [7:0]                 cfg_data,
  eafp_rx_if.sink                         rx,
  eafp_res_if.source                      res
);

  // Configuration registers
  logic [7:0] start_byte;
  logic [7:0] escape_byte;
  logic [7:0] escape_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte  <= eafp_pkg::START_BYTE_RST;
      escape_byte <= eafp_pkg::ESCAPE_BYTE_RST;
      escape_mask <= eafp_pkg::ESCAPE_MASK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        eafp_pkg::CFG_START_BYTE:  start_byte  <= cfg_data;
        eafp_pkg::CFG_ESCAPE_BYTE: escape_byte <= cfg_data;
        eafp_pkg::CFG_ESCAPE_MASK: escape_mask <= cfg_data;
        default: ;  // index with no register: write dropped
      endcase
    end
  end

  // Parser state
  eafp_pkg::phase_t    parse_phase, parse_phase_next;
  logic [LEN_BITS-1:0] length_reg, length_reg_next;
  logic [7:0]          running_sum, running_sum_next;
  logic [15:0]         payload_pos, payload_pos_next;

  // Result register
  logic                out_valid;
  logic                consumed, consumed_next;
  logic                data_valid, data_valid_next;
  logic [7:0]          data_byte, data_byte_next;
  logic [15:0]         data_index, data_index_next;
  logic [15:0]         frame_length;
  eafp_pkg::status_t   status;

  logic        rx_take;
  logic [7:0]  b;
  logic [7:0]  ub;
  logic        is_data;
  logic        escaped;
  logic [15:0] pos_inc;

  // Result slot is free when empty or being drained this cycle.
  assign rx.ready = !out_valid || res.ready;
  assign rx_take  = rx.valid && rx.ready;

  assign b       = rx.rx_byte;
  assign ub      = rx.rx_byte ^ escape_mask;
  assign pos_inc = payload_pos + 16'd1;

  // Judges the checksum byte against the payload sum.
  function automatic eafp_pkg::phase_t judge(input logic [7:0] ck, input logic [7:0] sum);
    logic [7:0] tot;
    tot = ck + sum;
    return (tot == eafp_pkg::CHECKSUM_OK) ? eafp_pkg::PH_GOOD : eafp_pkg::PH_BAD;
  endfunction

  always_comb begin
    parse_phase_next = parse_phase;
    length_reg_next  = length_reg;
    running_sum_next = running_sum;
    payload_pos_next = payload_pos;
    consumed_next    = 1'b0;
    data_valid_next  = 1'b0;
    data_byte_next   = 8'd0;
    data_index_next  = 16'd0;
    is_data          = 1'b0;
    escaped          = 1'b0;

    if (rx.kind) begin
      // restart: only the phase moves, the rest is cleared at the next start byte
      parse_phase_next = eafp_pkg::PH_WAIT;
    end else if (parse_phase == eafp_pkg::PH_WAIT) begin
      consumed_next = 1'b1;
      if (b == start_byte) begin
        parse_phase_next = eafp_pkg::PH_LEN1;
        length_reg_next  = '0;
        running_sum_next = 8'd0;
        payload_pos_next = 16'd0;
      end
    end else if (parse_phase == eafp_pkg::PH_GOOD || parse_phase == eafp_pkg::PH_BAD ||
                 parse_phase == eafp_pkg::PH_UNEXP) begin
      // done: hold until restart
    end else if (b == start_byte) begin
      parse_phase_next = eafp_pkg::PH_UNEXP;
    end else begin
      consumed_next = 1'b1;
      case (parse_phase)
        eafp_pkg::PH_LEN1: begin
          if (b == escape_byte) begin
            parse_phase_next = eafp_pkg::PH_LEN1_ESC;
          end else begin
            length_reg_next  = LEN_BITS'({b, 8'd0});
            parse_phase_next = eafp_pkg::PH_LEN2;
          end
        end
        eafp_pkg::PH_LEN1_ESC: begin
          length_reg_next  = LEN_BITS'({ub, 8'd0});
          parse_phase_next = eafp_pkg::PH_LEN2;
        end
        eafp_pkg::PH_LEN2: begin
          if (b == escape_byte) begin
            parse_phase_next = eafp_pkg::PH_LEN2_ESC;
          end else begin
            length_reg_next  = length_reg + LEN_BITS'(b);
            parse_phase_next = (length_reg_next == '0) ? eafp_pkg::PH_CK : eafp_pkg::PH_DATA;
          end
        end
        eafp_pkg::PH_LEN2_ESC: begin
          length_reg_next  = length_reg + LEN_BITS'(ub);
          parse_phase_next = (length_reg_next == '0) ? eafp_pkg::PH_CK : eafp_pkg::PH_DATA;
        end
        eafp_pkg::PH_DATA: begin
          if (b == escape_byte) begin
            parse_phase_next = eafp_pkg::PH_DATA_ESC;
          end else begin
            data_byte_next = b;
            is_data        = 1'b1;
          end
        end
        eafp_pkg::PH_DATA_ESC: begin
          data_byte_next = ub;
          is_data        = 1'b1;
          escaped        = 1'b1;
        end
        eafp_pkg::PH_CK: begin
          if (b == escape_byte) begin
            parse_phase_next = eafp_pkg::PH_CK_ESC;
          end else begin
            parse_phase_next = judge(b, running_sum);
          end
        end
        default: begin  // escaped checksum
          parse_phase_next = judge(ub, running_sum);
        end
      endcase

      if (is_data) begin
        data_valid_next  = 1'b1;
        data_index_next  = payload_pos;
        running_sum_next = running_sum + data_byte_next;
        payload_pos_next = pos_inc;
        if (pos_inc == 16'(length_reg)) begin
          parse_phase_next = eafp_pkg::PH_CK;
        end else if (escaped) begin
          parse_phase_next = eafp_pkg::PH_DATA;
        end
      end
    end
  end

  // State and valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= eafp_pkg::PH_WAIT;
      length_reg  <= '0;
      running_sum <= 8'd0;
      payload_pos <= 16'd0;
      out_valid   <= 1'b0;
    end else begin
      if (rx_take) begin
        parse_phase <= parse_phase_next;
        length_reg  <= length_reg_next;
        running_sum <= running_sum_next;
        payload_pos <= payload_pos_next;
        out_valid   <= 1'b1;
      end else if (res.ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted byte
  always_ff @(posedge clk) begin
    if (rx_take) begin
      consumed     <= consumed_next;
      data_valid   <= data_valid_next;
      data_byte    <= data_byte_next;
      data_index   <= data_index_next;
      frame_length <= 16'(length_reg_next);
      status       <= eafp_pkg::status_of(parse_phase_next);
    end
  end

  assign res.valid        = out_valid;
  assign res.consumed     = consumed;
  assign res.data_valid   = data_valid;
  assign res.data_byte    = data_byte;
  assign res.data_index   = data_index;
  assign res.frame_length = frame_length;
  assign res.status       = status;

endmodule

`default_nettype wire

### design/eafp_checker.sv
`default_nettype none

`include "escaped_api_frame_parser_macros.svh"

module eafp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              rx_valid,
  input wire logic              rx_ready,
  input wire logic              rx_kind,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire logic              res_consumed,
  input wire logic              res_data_valid,
  input wire logic [7:0]        res_data_byte,
  input wire logic [15:0]       res_data_index,
  input wire eafp_pkg::status_t res_status
);

  // held result keeps its payload
  `EAFP_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_data_byte) && $stable(res_status), "result changed while stalled")

  // a restart gives an unconsumed result in the waiting state
  `EAFP_ASSERT(a_restart, rx_valid && rx_ready && rx_kind |=> res_valid && !res_consumed && res_status == eafp_pkg::STATUS_WAIT, "restart result wrong")

  // payload bytes only come from a consumed byte inside a frame
  `EAFP_ASSERT(a_data_in_frame, res_valid && res_data_valid |-> res_consumed && res_status == eafp_pkg::STATUS_IN_FRAME, "payload outside frame")

  // no payload means zeroed data fields
  `EAFP_ASSERT(a_data_zero, res_valid && !res_data_valid |-> res_data_byte == 8'd0 && res_data_index == 16'd0, "stale data fields")

  // nothing pending straight after reset
  `EAFP_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid, "result valid after reset")

endmodule

bind escaped_api_frame_parser eafp_checker u_eafp_checker (
  .clk            (clk),
  .rst            (rst),
  .rx_valid       (rx.valid),
  .rx_ready       (rx.ready),
  .rx_kind        (rx.kind),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_consumed   (res.consumed),
  .res_data_valid (res.data_valid),
  .res_data_byte  (res.data_byte),
  .res_data_index (res.data_index),
  .res_status     (res.status)
);

`default_nettype wire
